FILE: rtl/polyev_pkg.sv
`default_nettype none

package polyev_pkg;

    // Field and register widths.
    parameter int DATA_W    = 32;
    parameter int PROD_W    = 2 * DATA_W;
    parameter int CFG_IDX_W = 3;
    parameter int DEGREE_W  = 3;

    // Configuration register indexes.
    parameter logic [CFG_IDX_W-1:0] REG_DEGREE = 3'd0;
    parameter logic [CFG_IDX_W-1:0] REG_COEF_0 = 3'd1;

    // Defaults for the top-level parameters.
    parameter int MAX_DEGREE_DEF = 6;
    parameter int FRAC_BITS_DEF  = 16;

    // Saturation bounds of the signed accumulator.
    parameter logic signed [DATA_W-1:0] ACC_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    parameter logic signed [DATA_W-1:0] ACC_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

`default_nettype wire

FILE: rtl/polynomial_evaluator.sv
`default_nettype none

// Streaming polynomial evaluator. Each x_value item on the slave side gives one result item:
// the polynomial of the configured degree (coefficients coef_0..coef_6 and degree written on
// the cfg port while the block is idle) evaluated at x in signed Q16.16 by Horner's rule, with
// every step saturated to 32 bits and the overflow flag set on tuser if any step clamped.
// The block takes one item per cycle while m_tready does not hold the pipeline. After an
// entry stage, each Horner step is a multiplier stage followed by a shift, add and saturate
// stage. Steps above the configured degree let the value pass unchanged, so latency does not
// depend on the degree.
module polynomial_evaluator #(
    parameter int MAX_DEGREE = polyev_pkg::MAX_DEGREE_DEF,
    parameter int FRAC_BITS  = polyev_pkg::FRAC_BITS_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // Configuration write port.
    input  wire                                 cfg_wr_en,
    input  wire  [polyev_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [polyev_pkg::DATA_W-1:0]       cfg_wr_data,
    // Input stream.
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [polyev_pkg::DATA_W-1:0]       s_tdata,   // [31:0] x_value
    // Output stream.
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [polyev_pkg::DATA_W-1:0]       m_tdata,   // [31:0] y_value
    output logic                                m_tuser    // [0] overflow
);

    localparam int DW     = polyev_pkg::DATA_W;
    localparam int PW     = polyev_pkg::PROD_W;
    localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
    localparam int LAST   = 2 * MAX_DEGREE;

    logic [polyev_pkg::DEGREE_W-1:0] degree_reg;
    logic signed [DW-1:0]            coef_reg [0:MAX_DEGREE];

    logic [polyev_pkg::DEGREE_W-1:0] deg_clip;
    logic [DEG_W-1:0]                d_eff;
    logic                            adv;

    // Even positions hold a Horner value, odd positions a product in flight.
    logic [LAST:0]          vld_reg;
    logic signed [DW-1:0]   x_reg    [0:LAST-2];
    logic signed [DW-1:0]   acc_reg  [0:LAST];
    logic signed [PW-1:0]   prod_reg [0:MAX_DEGREE-1];
    logic [LAST:0]          ovf_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg <= '0;
            for (int k = 0; k <= MAX_DEGREE; k++)
            begin
                coef_reg[k] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == polyev_pkg::REG_DEGREE)
            begin
                degree_reg <= cfg_wr_data[polyev_pkg::DEGREE_W-1:0];
            end
            for (int k = 0; k <= MAX_DEGREE; k++)
            begin
                if (cfg_index == polyev_pkg::REG_COEF_0 + polyev_pkg::CFG_IDX_W'(k))
                begin
                    coef_reg[k] <= cfg_wr_data;
                end
            end
        end
    end

    assign deg_clip = (degree_reg > polyev_pkg::DEGREE_W'(MAX_DEGREE))
                    ? polyev_pkg::DEGREE_W'(MAX_DEGREE) : degree_reg;
    assign d_eff    = deg_clip[DEG_W-1:0];

    // The whole pipeline moves when the output register is free or being taken.
    assign adv      = !vld_reg[LAST] || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAST-1:0], s_tvalid};
        end
    end

    // Entry stage: start from the coefficient of the highest power in use.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0]   <= s_tdata;
            acc_reg[0] <= coef_reg[d_eff];
            ovf_reg[0] <= 1'b0;
        end
    end

    for (genvar j = 0; j < MAX_DEGREE; j++)
    begin : g_step
        localparam int K = MAX_DEGREE - 1 - j;
        localparam int P = 2 * j + 1;

        logic signed [PW-1:0] shifted;
        logic signed [PW-1:0] sum;
        logic                 step_on;
        logic                 sat;

        assign shifted = prod_reg[j] >>> FRAC_BITS;
        assign sum     = shifted + PW'(coef_reg[K]);
        assign step_on = d_eff > DEG_W'(K);
        // The sum fits 32 bits only when its top bits are all copies of the sign.
        assign sat     = !((&sum[PW-1:DW-1]) || !(|sum[PW-1:DW-1]));

        // Multiplier stage.
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                prod_reg[j]  <= acc_reg[P-1] * x_reg[P-1];
                acc_reg[P]   <= acc_reg[P-1];
                ovf_reg[P]   <= ovf_reg[P-1];
            end
        end

        // Shift, add and saturate stage.
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (!step_on)
                begin
                    acc_reg[P+1] <= acc_reg[P];
                    ovf_reg[P+1] <= ovf_reg[P];
                end
                else if (sat)
                begin
                    acc_reg[P+1] <= sum[PW-1] ? polyev_pkg::ACC_MIN : polyev_pkg::ACC_MAX;
                    ovf_reg[P+1] <= 1'b1;
                end
                else
                begin
                    acc_reg[P+1] <= sum[DW-1:0];
                    ovf_reg[P+1] <= ovf_reg[P];
                end
            end
        end

        if (j < MAX_DEGREE - 1)
        begin : g_x
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    x_reg[P]   <= x_reg[P-1];
                    x_reg[P+1] <= x_reg[P];
                end
            end
        end

        // A step above the configured degree leaves value and flag as they were.
        a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
            (adv && vld_reg[P] && !step_on) |=>
                (acc_reg[P+1] == $past(acc_reg[P]) && ovf_reg[P+1] == $past(ovf_reg[P])))
            else $error("inactive Horner step changed the value");

        // Once a step has clamped, the flag stays set down the pipeline.
        a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
            (adv && vld_reg[P] && ovf_reg[P]) |=> ovf_reg[P+1])
            else $error("overflow flag lost between stages");
    end

    assign m_tvalid = vld_reg[LAST];
    assign m_tdata  = acc_reg[LAST];
    assign m_tuser  = ovf_reg[LAST];

    // A stalled pipeline keeps every valid bit in place.
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

endmodule

`default_nettype wire
